// ===== src/qcpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcpc_pkg
// Shared widths, register indexes, reset values and result codes of the quad
// cell plausibility check.
// ----------------------------------------------------------------------------
package qcpc_pkg;

    localparam int COORD_WIDTH_DEFAULT = 20;

    // Configuration register widths and the write port.
    localparam int AREA_WIDTH      = 24;
    localparam int EDGE_WIDTH      = 16;
    localparam int RATIO_WIDTH     = 12;
    localparam int RATIO_SQ_WIDTH  = 2 * RATIO_WIDTH;
    localparam int EDGE_SQ_WIDTH   = 2 * EDGE_WIDTH;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 24;

    // Register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_AREA           = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_EDGE_LENGTH    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_EDGE_RATIO     = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_DIAGONAL_RATIO = 2'd3;

    // Reset values: 15.0 px^2, 3.0 px, 2.4 and 2.0.
    localparam logic [AREA_WIDTH-1:0]  RESET_MIN_AREA           = 24'd3840;
    localparam logic [EDGE_WIDTH-1:0]  RESET_MIN_EDGE_LENGTH    = 16'd48;
    localparam logic [RATIO_WIDTH-1:0] RESET_MAX_EDGE_RATIO     = 12'd614;
    localparam logic [RATIO_WIDTH-1:0] RESET_MAX_DIAGONAL_RATIO = 12'd512;

    localparam logic [EDGE_SQ_WIDTH-1:0] RESET_MIN_EDGE_SQ =
        EDGE_SQ_WIDTH'(48 * 48);
    localparam logic [RATIO_SQ_WIDTH-1:0] RESET_EDGE_RATIO_SQ =
        RATIO_SQ_WIDTH'(614 * 614);
    localparam logic [RATIO_SQ_WIDTH-1:0] RESET_DIAGONAL_RATIO_SQ =
        RATIO_SQ_WIDTH'(512 * 512);

    // Result codes, first failing check.
    localparam logic [2:0] FC_PASS           = 3'd0;
    localparam logic [2:0] FC_NONFINITE      = 3'd1;
    localparam logic [2:0] FC_AREA           = 3'd2;
    localparam logic [2:0] FC_NONCONVEX      = 3'd3;
    localparam logic [2:0] FC_SHORT_EDGE     = 3'd4;
    localparam logic [2:0] FC_EDGE_RATIO     = 3'd5;
    localparam logic [2:0] FC_SHORT_DIAGONAL = 3'd6;
    localparam logic [2:0] FC_DIAGONAL_RATIO = 3'd7;

endpackage

// ===== src/quad_cell_plausibility_check_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_cell_plausibility_check_core
// Seven-stage pipeline that decides whether four corners form a plausible
// checkerboard cell and reports the first failing check.
// ----------------------------------------------------------------------------
// Usage:
// An item (coords_finite and four corners x0,y0 .. x3,y3) enters when in_valid
// is high and in_stall is low. Exactly one result (plausible, fail_code)
// leaves per item, in order, when out_valid is high and out_stall is low.
// Throughput is one item per cycle when out_stall is low; out_valid is the
// valid bit of the last stage. The seven stages are: differences, products,
// sums, area and convexity tests with pairwise min/max, final min/max and
// short diagonal test, short edge test and ratio partial products, ratio
// compare and code selection.
// Each stage moves whenever it is empty or the stage after it moves, so
// bubbles close up and a stalled output stops only the full stages behind it.
// in_stall rises only when all stages hold items and the output is stalled.
// The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no item is in flight.
// Reset empties the pipeline and loads the default thresholds.
// ----------------------------------------------------------------------------
module quad_cell_plausibility_check_core #(
    parameter int COORD_WIDTH = qcpc_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qcpc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [qcpc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    // Input items
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   coords_finite,
    input  logic signed [COORD_WIDTH-1:0]          x0,
    input  logic signed [COORD_WIDTH-1:0]          y0,
    input  logic signed [COORD_WIDTH-1:0]          x1,
    input  logic signed [COORD_WIDTH-1:0]          y1,
    input  logic signed [COORD_WIDTH-1:0]          x2,
    input  logic signed [COORD_WIDTH-1:0]          y2,
    input  logic signed [COORD_WIDTH-1:0]          x3,
    input  logic signed [COORD_WIDTH-1:0]          y3,
    // Results
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   plausible,
    output logic [2:0]                             fail_code
);

    localparam int DW  = COORD_WIDTH + 1;             // coordinate difference
    localparam int PW  = 2 * DW;                      // signed product
    localparam int CW  = 2 * COORD_WIDTH + 4;         // cross product, area sum
    localparam int LW  = 2 * COORD_WIDTH + 2;         // squared length
    localparam int QW  = (LW > qcpc_pkg::EDGE_SQ_WIDTH) ? LW : qcpc_pkg::EDGE_SQ_WIDTH;
    localparam int HW  = DW;                          // low half of a length
    localparam int PPW = HW + qcpc_pkg::RATIO_SQ_WIDTH;
    localparam int RW  = LW + qcpc_pkg::RATIO_SQ_WIDTH;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [qcpc_pkg::AREA_WIDTH-1:0]     min_area_reg;
    logic [qcpc_pkg::EDGE_WIDTH-1:0]     min_edge_length_reg;
    logic [qcpc_pkg::RATIO_WIDTH-1:0]    max_edge_ratio_reg;
    logic [qcpc_pkg::RATIO_WIDTH-1:0]    max_diagonal_ratio_reg;
    logic [qcpc_pkg::EDGE_SQ_WIDTH-1:0]  min_edge_sq_reg, min_edge_sq_next;
    logic [qcpc_pkg::RATIO_SQ_WIDTH-1:0] edge_ratio_sq_reg, edge_ratio_sq_next;
    logic [qcpc_pkg::RATIO_SQ_WIDTH-1:0] diag_ratio_sq_reg, diag_ratio_sq_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_area_reg           <= qcpc_pkg::RESET_MIN_AREA;
            min_edge_length_reg    <= qcpc_pkg::RESET_MIN_EDGE_LENGTH;
            max_edge_ratio_reg     <= qcpc_pkg::RESET_MAX_EDGE_RATIO;
            max_diagonal_ratio_reg <= qcpc_pkg::RESET_MAX_DIAGONAL_RATIO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                qcpc_pkg::CFG_MIN_AREA:
                    min_area_reg <= cfg_data[qcpc_pkg::AREA_WIDTH-1:0];
                qcpc_pkg::CFG_MIN_EDGE_LENGTH:
                    min_edge_length_reg <= cfg_data[qcpc_pkg::EDGE_WIDTH-1:0];
                qcpc_pkg::CFG_MAX_EDGE_RATIO:
                    max_edge_ratio_reg <= cfg_data[qcpc_pkg::RATIO_WIDTH-1:0];
                qcpc_pkg::CFG_MAX_DIAGONAL_RATIO:
                    max_diagonal_ratio_reg <= cfg_data[qcpc_pkg::RATIO_WIDTH-1:0];
            endcase
        end
    end

    // Squared thresholds follow the registers in the next cycle, well before
    // any item that entered after a write reaches the stages that use them.
    assign min_edge_sq_next = qcpc_pkg::EDGE_SQ_WIDTH'(min_edge_length_reg)
                            * qcpc_pkg::EDGE_SQ_WIDTH'(min_edge_length_reg);
    assign edge_ratio_sq_next = qcpc_pkg::RATIO_SQ_WIDTH'(max_edge_ratio_reg)
                              * qcpc_pkg::RATIO_SQ_WIDTH'(max_edge_ratio_reg);
    assign diag_ratio_sq_next = qcpc_pkg::RATIO_SQ_WIDTH'(max_diagonal_ratio_reg)
                              * qcpc_pkg::RATIO_SQ_WIDTH'(max_diagonal_ratio_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_edge_sq_reg   <= qcpc_pkg::RESET_MIN_EDGE_SQ;
            edge_ratio_sq_reg <= qcpc_pkg::RESET_EDGE_RATIO_SQ;
            diag_ratio_sq_reg <= qcpc_pkg::RESET_DIAGONAL_RATIO_SQ;
        end
        else
        begin
            min_edge_sq_reg   <= min_edge_sq_next;
            edge_ratio_sq_reg <= edge_ratio_sq_next;
            diag_ratio_sq_reg <= diag_ratio_sq_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en7;

    assign en7 = !s7_valid_reg || !out_stall;
    assign en6 = !s6_valid_reg || en7;
    assign en5 = !s5_valid_reg || en6;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= in_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
            if (en5) s5_valid_reg <= s4_valid_reg;
            if (en6) s6_valid_reg <= s5_valid_reg;
            if (en7) s7_valid_reg <= s6_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: coordinate differences
    // Edge i runs from corner i to corner i+1; diagonals are 0->2 and 1->3;
    // the last vector, 0->3, closes the shoelace sum.
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] px [4];
    logic signed [COORD_WIDTH-1:0] py [4];

    assign px[0] = x0;
    assign px[1] = x1;
    assign px[2] = x2;
    assign px[3] = x3;
    assign py[0] = y0;
    assign py[1] = y1;
    assign py[2] = y2;
    assign py[3] = y3;

    logic                 s1_finite_reg;
    logic signed [DW-1:0] s1_ex_reg [4], s1_ex_next [4];
    logic signed [DW-1:0] s1_ey_reg [4], s1_ey_next [4];
    logic signed [DW-1:0] s1_dx_reg [2], s1_dx_next [2];
    logic signed [DW-1:0] s1_dy_reg [2], s1_dy_next [2];
    logic signed [DW-1:0] s1_fx_reg, s1_fx_next;
    logic signed [DW-1:0] s1_fy_reg, s1_fy_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s1_ex_next[i] = DW'(px[(i + 1) % 4]) - DW'(px[i]);
            s1_ey_next[i] = DW'(py[(i + 1) % 4]) - DW'(py[i]);
        end
        for (int i = 0; i < 2; i++)
        begin
            s1_dx_next[i] = DW'(px[i + 2]) - DW'(px[i]);
            s1_dy_next[i] = DW'(py[i + 2]) - DW'(py[i]);
        end
        s1_fx_next = DW'(px[3]) - DW'(px[0]);
        s1_fy_next = DW'(py[3]) - DW'(py[0]);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_finite_reg <= coords_finite;
            s1_ex_reg     <= s1_ex_next;
            s1_ey_reg     <= s1_ey_next;
            s1_dx_reg     <= s1_dx_next;
            s1_dy_reg     <= s1_dy_next;
            s1_fx_reg     <= s1_fx_next;
            s1_fy_reg     <= s1_fy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products
    // Area terms: cross(edge 0, diag 0) and cross(diag 0, vector 0->3).
    // Corner terms: cross(edge i, edge i+1). Squares: edges, then diagonals.
    // ------------------------------------------------------------------
    logic                 s2_finite_reg;
    logic signed [PW-1:0] s2_ap_reg [4],  s2_ap_next [4];
    logic signed [PW-1:0] s2_cp_reg [8],  s2_cp_next [8];
    logic signed [PW-1:0] s2_sq_reg [12], s2_sq_next [12];

    always_comb
    begin
        s2_ap_next[0] = s1_ex_reg[0] * s1_dy_reg[0];
        s2_ap_next[1] = s1_ey_reg[0] * s1_dx_reg[0];
        s2_ap_next[2] = s1_dx_reg[0] * s1_fy_reg;
        s2_ap_next[3] = s1_dy_reg[0] * s1_fx_reg;
        for (int i = 0; i < 4; i++)
        begin
            s2_cp_next[2 * i]     = s1_ex_reg[i] * s1_ey_reg[(i + 1) % 4];
            s2_cp_next[2 * i + 1] = s1_ey_reg[i] * s1_ex_reg[(i + 1) % 4];
            s2_sq_next[2 * i]     = s1_ex_reg[i] * s1_ex_reg[i];
            s2_sq_next[2 * i + 1] = s1_ey_reg[i] * s1_ey_reg[i];
        end
        for (int i = 0; i < 2; i++)
        begin
            s2_sq_next[8 + 2 * i]     = s1_dx_reg[i] * s1_dx_reg[i];
            s2_sq_next[8 + 2 * i + 1] = s1_dy_reg[i] * s1_dy_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_finite_reg <= s1_finite_reg;
            s2_ap_reg     <= s2_ap_next;
            s2_cp_reg     <= s2_cp_next;
            s2_sq_reg     <= s2_sq_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: doubled area, corner cross products and squared lengths
    // ------------------------------------------------------------------
    logic                 s3_finite_reg;
    logic signed [CW-1:0] s3_area_reg, s3_area_next;
    logic signed [CW-1:0] s3_cross_reg [4], s3_cross_next [4];
    logic [LW-1:0]        s3_edge_reg [4], s3_edge_next [4];
    logic [LW-1:0]        s3_diag_reg [2], s3_diag_next [2];

    always_comb
    begin
        s3_area_next = CW'(s2_ap_reg[0]) - CW'(s2_ap_reg[1])
                     + CW'(s2_ap_reg[2]) - CW'(s2_ap_reg[3]);
        for (int i = 0; i < 4; i++)
        begin
            s3_cross_next[i] = CW'(s2_cp_reg[2 * i]) - CW'(s2_cp_reg[2 * i + 1]);
            s3_edge_next[i]  = LW'($unsigned(s2_sq_reg[2 * i]))
                             + LW'($unsigned(s2_sq_reg[2 * i + 1]));
        end
        for (int i = 0; i < 2; i++)
        begin
            s3_diag_next[i] = LW'($unsigned(s2_sq_reg[8 + 2 * i]))
                            + LW'($unsigned(s2_sq_reg[8 + 2 * i + 1]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_finite_reg <= s2_finite_reg;
            s3_area_reg   <= s3_area_next;
            s3_cross_reg  <= s3_cross_next;
            s3_edge_reg   <= s3_edge_next;
            s3_diag_reg   <= s3_diag_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: area and convexity tests, pairwise edge min/max, diagonals
    // ------------------------------------------------------------------
    logic                 s4_finite_reg;
    logic                 s4_area_fail_reg, s4_area_fail_next;
    logic                 s4_convex_fail_reg, s4_convex_fail_next;
    logic [LW-1:0]        s4_emn_reg [2], s4_emn_next [2];
    logic [LW-1:0]        s4_emx_reg [2], s4_emx_next [2];
    logic [LW-1:0]        s4_dmn_reg, s4_dmn_next;
    logic [LW-1:0]        s4_dmx_reg, s4_dmx_next;
    logic signed [CW-1:0] area_lim;
    logic [3:0]           cross_neg;
    logic [3:0]           cross_zero;

    // The area is |S|/2, so it fails when S lies strictly between -2m and 2m.
    assign area_lim = $signed(CW'({min_area_reg, 1'b0}));

    always_comb
    begin
        s4_area_fail_next = (s3_area_reg < area_lim) && (s3_area_reg > -area_lim);
        for (int i = 0; i < 4; i++)
        begin
            cross_neg[i]  = s3_cross_reg[i][CW-1];
            cross_zero[i] = (s3_cross_reg[i] == '0);
        end
        s4_convex_fail_next = (|cross_zero) || ((|cross_neg) && !(&cross_neg));
        for (int i = 0; i < 2; i++)
        begin
            if (s3_edge_reg[2 * i] < s3_edge_reg[2 * i + 1])
            begin
                s4_emn_next[i] = s3_edge_reg[2 * i];
                s4_emx_next[i] = s3_edge_reg[2 * i + 1];
            end
            else
            begin
                s4_emn_next[i] = s3_edge_reg[2 * i + 1];
                s4_emx_next[i] = s3_edge_reg[2 * i];
            end
        end
        if (s3_diag_reg[0] <= s3_diag_reg[1])
        begin
            s4_dmn_next = s3_diag_reg[0];
            s4_dmx_next = s3_diag_reg[1];
        end
        else
        begin
            s4_dmn_next = s3_diag_reg[1];
            s4_dmx_next = s3_diag_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_finite_reg      <= s3_finite_reg;
            s4_area_fail_reg   <= s4_area_fail_next;
            s4_convex_fail_reg <= s4_convex_fail_next;
            s4_emn_reg         <= s4_emn_next;
            s4_emx_reg         <= s4_emx_next;
            s4_dmn_reg         <= s4_dmn_next;
            s4_dmx_reg         <= s4_dmx_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: final edge min/max, short diagonal test
    // ------------------------------------------------------------------
    logic          s5_finite_reg;
    logic          s5_area_fail_reg;
    logic          s5_convex_fail_reg;
    logic          s5_short_diag_reg, s5_short_diag_next;
    logic [LW-1:0] s5_emn_reg, s5_emn_next;
    logic [LW-1:0] s5_emx_reg, s5_emx_next;
    logic [LW-1:0] s5_dmn_reg;
    logic [LW-1:0] s5_dmx_reg;

    always_comb
    begin
        s5_emn_next = (s4_emn_reg[0] < s4_emn_reg[1]) ? s4_emn_reg[0] : s4_emn_reg[1];
        s5_emx_next = (s4_emx_reg[0] > s4_emx_reg[1]) ? s4_emx_reg[0] : s4_emx_reg[1];
        s5_short_diag_next = QW'(s4_dmn_reg) < QW'(min_edge_sq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_finite_reg      <= s4_finite_reg;
            s5_area_fail_reg   <= s4_area_fail_reg;
            s5_convex_fail_reg <= s4_convex_fail_reg;
            s5_short_diag_reg  <= s5_short_diag_next;
            s5_emn_reg         <= s5_emn_next;
            s5_emx_reg         <= s5_emx_next;
            s5_dmn_reg         <= s4_dmn_reg;
            s5_dmx_reg         <= s4_dmx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: short edge test, ratio partial products
    // The shorter length is split into two halves so that each multiply by
    // the squared ratio stays narrow.
    // ------------------------------------------------------------------
    logic           s6_finite_reg;
    logic           s6_area_fail_reg;
    logic           s6_convex_fail_reg;
    logic           s6_short_diag_reg;
    logic           s6_short_edge_reg, s6_short_edge_next;
    logic [LW-1:0]  s6_emx_reg;
    logic [LW-1:0]  s6_dmx_reg;
    logic [PPW-1:0] s6_epp_lo_reg, s6_epp_lo_next;
    logic [PPW-1:0] s6_epp_hi_reg, s6_epp_hi_next;
    logic [PPW-1:0] s6_dpp_lo_reg, s6_dpp_lo_next;
    logic [PPW-1:0] s6_dpp_hi_reg, s6_dpp_hi_next;

    always_comb
    begin
        s6_short_edge_next = QW'(s5_emn_reg) < QW'(min_edge_sq_reg);
        s6_epp_lo_next = PPW'(s5_emn_reg[HW-1:0]) * PPW'(edge_ratio_sq_reg);
        s6_epp_hi_next = PPW'(s5_emn_reg[LW-1:HW]) * PPW'(edge_ratio_sq_reg);
        s6_dpp_lo_next = PPW'(s5_dmn_reg[HW-1:0]) * PPW'(diag_ratio_sq_reg);
        s6_dpp_hi_next = PPW'(s5_dmn_reg[LW-1:HW]) * PPW'(diag_ratio_sq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_finite_reg      <= s5_finite_reg;
            s6_area_fail_reg   <= s5_area_fail_reg;
            s6_convex_fail_reg <= s5_convex_fail_reg;
            s6_short_diag_reg  <= s5_short_diag_reg;
            s6_short_edge_reg  <= s6_short_edge_next;
            s6_emx_reg         <= s5_emx_reg;
            s6_dmx_reg         <= s5_dmx_reg;
            s6_epp_lo_reg      <= s6_epp_lo_next;
            s6_epp_hi_reg      <= s6_epp_hi_next;
            s6_dpp_lo_reg      <= s6_dpp_lo_next;
            s6_dpp_hi_reg      <= s6_dpp_hi_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: ratio compares and code selection into the output register
    // A ratio fails when 65536 * longer^2 > ratio^2 * shorter^2.
    // ------------------------------------------------------------------
    logic [RW-1:0] edge_rhs, diag_rhs, edge_lhs, diag_lhs;
    logic          edge_ratio_fail, diag_ratio_fail;
    logic [2:0]    s7_code_reg, s7_code_next;

    always_comb
    begin
        edge_rhs = RW'(s6_epp_lo_reg) + (RW'(s6_epp_hi_reg) << HW);
        diag_rhs = RW'(s6_dpp_lo_reg) + (RW'(s6_dpp_hi_reg) << HW);
        edge_lhs = RW'({s6_emx_reg, 16'h0000});
        diag_lhs = RW'({s6_dmx_reg, 16'h0000});
        edge_ratio_fail = edge_lhs > edge_rhs;
        diag_ratio_fail = diag_lhs > diag_rhs;

        priority if (!s6_finite_reg)
            s7_code_next = qcpc_pkg::FC_NONFINITE;
        else if (s6_area_fail_reg)
            s7_code_next = qcpc_pkg::FC_AREA;
        else if (s6_convex_fail_reg)
            s7_code_next = qcpc_pkg::FC_NONCONVEX;
        else if (s6_short_edge_reg)
            s7_code_next = qcpc_pkg::FC_SHORT_EDGE;
        else if (edge_ratio_fail)
            s7_code_next = qcpc_pkg::FC_EDGE_RATIO;
        else if (s6_short_diag_reg)
            s7_code_next = qcpc_pkg::FC_SHORT_DIAGONAL;
        else if (diag_ratio_fail)
            s7_code_next = qcpc_pkg::FC_DIAGONAL_RATIO;
        else
            s7_code_next = qcpc_pkg::FC_PASS;
    end

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            s7_code_reg <= s7_code_next;
        end
    end

    assign out_valid = s7_valid_reg;
    assign fail_code = s7_code_reg;
    assign plausible = (s7_code_reg == qcpc_pkg::FC_PASS);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The input side may only back up when every stage is full and the
    // output is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && s1_valid_reg && s4_valid_reg))
        else $error("input stalled while the pipeline has room");

    // A stalled output stage keeps its item and its code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s7_valid_reg && out_stall) |=> (s7_valid_reg && $stable(s7_code_reg)))
        else $error("output stage changed while stalled");

    // A full stage 6 that cannot move keeps its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s6_valid_reg && !en7) |=> s6_valid_reg)
        else $error("item lost in stage 6 during a stall");

endmodule

// ===== sim/tb_quad_cell_plausibility_check_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_cell_plausibility_check_core
// Self-checking bench for the quad cell plausibility check. A short table of
// hand-made cells covers every fail code and the threshold boundaries. It is
// followed by randomized near-rectangular cells, degenerate and noise quads
// under several threshold settings. Every result is compared with a tabled
// or behavioral verdict computed in wide integers, while both handshakes idle
// at random and the output side holds off once long enough to fill the pipe.
// ----------------------------------------------------------------------------
module tb_quad_cell_plausibility_check_core;

    localparam int CW              = qcpc_pkg::COORD_WIDTH_DEFAULT;
    localparam int HALF_PERIOD     = 2;
    localparam int PIPE_LATENCY    = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 8;
    localparam int NUM_ROWS        = 23;
    localparam int PRESSURE_AT     = 1600;
    localparam int PRESSURE_CYCLES = 64;
    localparam int CYCLE_LIMIT     = 100000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic                 finite;
        logic signed [CW-1:0] x[4];
        logic signed [CW-1:0] y[4];
    } quad_t;

    typedef struct packed {
        logic       plausible;
        logic [2:0] code;
    } verdict_t;

    // One hand-made cell: finite flag, x0,y0 .. x3,y3, and the code when it is
    // obvious; rows with known = 0 go through the predictor.
    typedef struct {
        logic       finite;
        int         c[8];
        logic       known;
        logic [2:0] code;
    } cell_row_t;

    cell_row_t cell_table [NUM_ROWS] = '{
        '{1'b0, '{12345, -6789, -524288, 524287, 1, -1, 0, 99999},
          1'b1, qcpc_pkg::FC_NONFINITE},
        '{1'b0, '{524287, 524287, 524287, 524287, 524287, 524287, 524287, 524287},
          1'b1, qcpc_pkg::FC_NONFINITE},
        '{1'b0, '{-524288, -524288, -524288, -524288, -524288, -524288, -524288, -524288},
          1'b1, qcpc_pkg::FC_NONFINITE},
        '{1'b1, '{0, 0, 160, 0, 160, 160, 0, 160}, 1'b1, qcpc_pkg::FC_PASS},
        '{1'b1, '{0, 0, 0, 160, 160, 160, 160, 0}, 1'b1, qcpc_pkg::FC_PASS},
        '{1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, qcpc_pkg::FC_AREA},
        '{1'b1, '{524287, 524287, 524287, 524287, 524287, 524287, 524287, 524287},
          1'b1, qcpc_pkg::FC_AREA},
        '{1'b1, '{-524288, -524288, -524288, -524288, -524288, -524288, -524288, -524288},
          1'b1, qcpc_pkg::FC_AREA},
        '{1'b1, '{0, 0, 80, 0, 80, 48, 0, 48}, 1'b1, qcpc_pkg::FC_PASS},
        '{1'b1, '{0, 0, 80, 0, 80, 47, 0, 47}, 1'b1, qcpc_pkg::FC_AREA},
        '{1'b1, '{0, 0, 320, 0, 80, 80, 0, 320}, 1'b1, qcpc_pkg::FC_NONCONVEX},
        '{1'b1, '{0, 0, 160, 0, 320, 0, 0, 320}, 1'b1, qcpc_pkg::FC_NONCONVEX},
        '{1'b1, '{0, 0, 160, 160, 160, 0, 0, 160}, 1'b0, qcpc_pkg::FC_PASS},
        '{1'b1, '{0, 0, 1600, 0, 1600, 32, 0, 32}, 1'b1, qcpc_pkg::FC_SHORT_EDGE},
        '{1'b1, '{0, 0, 480, 0, 480, 160, 0, 160}, 1'b1, qcpc_pkg::FC_EDGE_RATIO},
        '{1'b1, '{0, 0, 614, 0, 614, 256, 0, 256}, 1'b1, qcpc_pkg::FC_PASS},
        '{1'b1, '{0, 0, 615, 0, 615, 256, 0, 256}, 1'b1, qcpc_pkg::FC_EDGE_RATIO},
        '{1'b1, '{0, 0, 200, 20, 400, 0, 200, -20}, 1'b1, qcpc_pkg::FC_SHORT_DIAGONAL},
        '{1'b1, '{0, 0, 160, 0, 480, 160, 320, 160}, 1'b1, qcpc_pkg::FC_DIAGONAL_RATIO},
        '{1'b1, '{-524288, -524288, 524287, -524288, 524287, 524287, -524288, 524287},
          1'b1, qcpc_pkg::FC_PASS},
        '{1'b1, '{-524288, -524288, -524288, 524287, 524287, 524287, 524287, -524288},
          1'b1, qcpc_pkg::FC_PASS},
        '{1'b1, '{349525, 349525, -349526, 349525, -349526, -349526, 349525, -349526},
          1'b0, qcpc_pkg::FC_PASS},
        '{1'b1, '{-100, -50, 300, -40, 420, 210, -30, 190}, 1'b0, qcpc_pkg::FC_PASS}
    };

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 cfg_valid     = 1'b0;
    logic                                 cfg_ready;
    logic [qcpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index     = '0;
    logic [qcpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data      = '0;
    logic                                 in_valid      = 1'b0;
    logic                                 in_stall;
    logic                                 coords_finite = 1'b0;
    logic signed [CW-1:0]                 x0 = '0;
    logic signed [CW-1:0]                 y0 = '0;
    logic signed [CW-1:0]                 x1 = '0;
    logic signed [CW-1:0]                 y1 = '0;
    logic signed [CW-1:0]                 x2 = '0;
    logic signed [CW-1:0]                 y2 = '0;
    logic signed [CW-1:0]                 x3 = '0;
    logic signed [CW-1:0]                 y3 = '0;
    logic                                 out_valid;
    logic                                 out_stall     = 1'b0;
    logic                                 plausible;
    logic [2:0]                           fail_code;

    // Thresholds as the block should hold them.
    logic [qcpc_pkg::AREA_WIDTH-1:0]  thr_area       = qcpc_pkg::RESET_MIN_AREA;
    logic [qcpc_pkg::EDGE_WIDTH-1:0]  thr_edge       = qcpc_pkg::RESET_MIN_EDGE_LENGTH;
    logic [qcpc_pkg::RATIO_WIDTH-1:0] thr_edge_ratio = qcpc_pkg::RESET_MAX_EDGE_RATIO;
    logic [qcpc_pkg::RATIO_WIDTH-1:0] thr_diag_ratio = qcpc_pkg::RESET_MAX_DIAGONAL_RATIO;

    verdict_t awaited_verdicts[$];
    int       n_sent        = 0;
    int       n_results     = 0;
    int       n_mismatch    = 0;
    int       idle_mode     = 0;
    int       hold_left     = 0;
    bit       pressure_done = 1'b0;
    int       cycle_count   = 0;

    quad_cell_plausibility_check_core #(
        .COORD_WIDTH(CW)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .coords_finite(coords_finite),
        .x0           (x0),
        .y0           (y0),
        .x1           (x1),
        .y1           (y1),
        .x2           (x2),
        .y2           (y2),
        .x3           (x3),
        .y3           (y3),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .plausible    (plausible),
        .fail_code    (fail_code)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic wide_t cross2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
        return ax * by - ay * bx;
    endfunction

    function automatic wide_t sq_len(wide_t dx, wide_t dy);
        return dx * dx + dy * dy;
    endfunction

    function automatic bit ratio_over(wide_t longer, wide_t shorter,
                                      logic [qcpc_pkg::RATIO_WIDTH-1:0] r);
        wide_t rw;
        rw = wide_t'(r);
        return longer * 65536 > rw * rw * shorter;
    endfunction

    // First failing check of a quad under the current thresholds.
    function automatic logic [2:0] cell_verdict(quad_t q);
        wide_t xs[4];
        wide_t ys[4];
        wide_t e2[4];
        wide_t area2, cr, lo, hi, d0, d1, lim;
        int    sgn, cur, i, j, k;
        if (!q.finite)
            return qcpc_pkg::FC_NONFINITE;
        for (i = 0; i < 4; i++)
        begin
            xs[i] = wide_t'(q.x[i]);
            ys[i] = wide_t'(q.y[i]);
        end
        area2 = cross2(xs[1] - xs[0], ys[1] - ys[0], xs[2] - xs[0], ys[2] - ys[0])
              + cross2(xs[2] - xs[0], ys[2] - ys[0], xs[3] - xs[0], ys[3] - ys[0]);
        if (area2 < 0)
            area2 = -area2;
        lim = wide_t'(thr_area);
        if (area2 < lim * 2)
            return qcpc_pkg::FC_AREA;
        sgn = 0;
        for (i = 0; i < 4; i++)
        begin
            j  = (i + 1) % 4;
            k  = (i + 2) % 4;
            cr = cross2(xs[j] - xs[i], ys[j] - ys[i], xs[k] - xs[j], ys[k] - ys[j]);
            if (cr == 0)
                return qcpc_pkg::FC_NONCONVEX;
            cur = (cr < 0) ? -1 : 1;
            if (sgn != 0 && cur != sgn)
                return qcpc_pkg::FC_NONCONVEX;
            sgn = cur;
        end
        for (i = 0; i < 4; i++)
        begin
            j     = (i + 1) % 4;
            e2[i] = sq_len(xs[j] - xs[i], ys[j] - ys[i]);
        end
        lo = e2[0];
        hi = e2[0];
        for (i = 1; i < 4; i++)
        begin
            if (e2[i] < lo)
                lo = e2[i];
            if (e2[i] > hi)
                hi = e2[i];
        end
        lim = wide_t'(thr_edge);
        lim = lim * lim;
        if (lo < lim)
            return qcpc_pkg::FC_SHORT_EDGE;
        if (ratio_over(hi, lo, thr_edge_ratio))
            return qcpc_pkg::FC_EDGE_RATIO;
        d0 = sq_len(xs[2] - xs[0], ys[2] - ys[0]);
        d1 = sq_len(xs[3] - xs[1], ys[3] - ys[1]);
        lo = (d0 <= d1) ? d0 : d1;
        hi = (d0 <= d1) ? d1 : d0;
        if (lo < lim)
            return qcpc_pkg::FC_SHORT_DIAGONAL;
        if (ratio_over(hi, lo, thr_diag_ratio))
            return qcpc_pkg::FC_DIAGONAL_RATIO;
        return qcpc_pkg::FC_PASS;
    endfunction

    // Mostly sheared and jittered rectangles at random places, some with three
    // corners in line, plus raw noise and nonfinite items.
    function automatic quad_t random_cell();
        quad_t q;
        int    pick, hw, hh, sh, jit, ext, span, cx, cy, k, src, first, tmp;
        bit    rev;
        int    px[4];
        int    py[4];
        pick     = int'($urandom_range(0, 99));
        q.finite = 1'b1;
        if (pick < 20)
        begin
            q.finite = (pick >= 5);
            for (k = 0; k < 4; k++)
            begin
                q.x[k] = CW'($urandom);
                q.y[k] = CW'($urandom);
            end
            return q;
        end
        hw = ($urandom_range(0, 9) == 0) ? int'($urandom_range(400, 50000))
                                         : int'($urandom_range(8, 400));
        hh = hw * int'($urandom_range(10, 300)) / 100 + 1;
        if (hh > 50000)
            hh = 50000;
        sh  = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 2 * hw)) - hw : 0;
        jit = int'($urandom_range(0, hw / 4));
        ext = hw + hh + ((sh < 0) ? -sh : sh) + jit + 1;
        // Corners may land up to three extents from the center.
        span = 524287 - 3 * ext;
        cx   = int'($urandom_range(0, 2 * span)) - span;
        cy   = int'($urandom_range(0, 2 * span)) - span;
        px[0] = -hw - sh;
        py[0] = -hh;
        px[1] = hw - sh;
        py[1] = -hh;
        px[2] = hw + sh;
        py[2] = hh;
        px[3] = -hw + sh;
        py[3] = hh;
        for (k = 0; k < 4; k++)
        begin
            px[k] += int'($urandom_range(0, 2 * jit)) - jit;
            py[k] += int'($urandom_range(0, 2 * jit)) - jit;
        end
        if (pick < 25)
        begin
            px[1] = 2 * px[0] - px[3];
            py[1] = 2 * py[0] - py[3];
        end
        if ($urandom_range(0, 1) == 1)
        begin
            for (k = 0; k < 4; k++)
            begin
                tmp   = px[k];
                px[k] = py[k];
                py[k] = tmp;
            end
        end
        first = int'($urandom_range(0, 3));
        rev   = 1'($urandom_range(0, 1));
        for (k = 0; k < 4; k++)
        begin
            src    = rev ? ((first - k) & 3) : ((first + k) & 3);
            q.x[k] = CW'(cx + px[src]);
            q.y[k] = CW'(cy + py[src]);
        end
        return q;
    endfunction

    task automatic write_threshold(input logic [qcpc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                   input logic [qcpc_pkg::CFG_DATA_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            qcpc_pkg::CFG_MIN_AREA:
                thr_area = value[qcpc_pkg::AREA_WIDTH-1:0];
            qcpc_pkg::CFG_MIN_EDGE_LENGTH:
                thr_edge = value[qcpc_pkg::EDGE_WIDTH-1:0];
            qcpc_pkg::CFG_MAX_EDGE_RATIO:
                thr_edge_ratio = value[qcpc_pkg::RATIO_WIDTH-1:0];
            qcpc_pkg::CFG_MAX_DIAGONAL_RATIO:
                thr_diag_ratio = value[qcpc_pkg::RATIO_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input quad_t q, input verdict_t v);
        int idle_pct;
        idle_pct = (idle_mode == 0) ? 9 : (idle_mode == 1) ? 48 : 0;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        coords_finite <= q.finite;
        x0            <= q.x[0];
        y0            <= q.y[0];
        x1            <= q.x[1];
        y1            <= q.y[1];
        x2            <= q.x[2];
        y2            <= q.y[2];
        x3            <= q.x[3];
        y3            <= q.y[3];
        do @(posedge clk); while (in_stall);
        awaited_verdicts = {awaited_verdicts, v};
        n_sent++;
        idle_mode = (n_sent < 700) ? 0 : (n_sent < 1400) ? 1 : 2;
    endtask

    // Output side: random stalls, and once a long hold-off so the pipe fills.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (!pressure_done && n_results >= PRESSURE_AT)
        begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_CYCLES - 1;
            out_stall    <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) <
                          ((idle_mode == 0) ? 48 : (idle_mode == 1) ? 9 : 0));
        end
    end

    always @(posedge clk)
    begin : check_result
        verdict_t head;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_verdicts.size() == 0)
            begin
                $error("result with no item pending: plausible %0b, fail_code %0d",
                       plausible, fail_code);
                n_mismatch++;
            end
            else
            begin
                head = awaited_verdicts.pop_front();
                if (plausible !== head.plausible)
                begin
                    $error("plausible: expected %0b, actual %0b", head.plausible, plausible);
                    n_mismatch++;
                end
                if (fail_code !== head.code)
                begin
                    $error("fail_code: expected %0d, actual %0d", head.code, fail_code);
                    n_mismatch++;
                end
            end
            n_results++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        quad_t                            q;
        verdict_t                         v;
        int                               k, phase, n;
        logic [qcpc_pkg::AREA_WIDTH-1:0]  area_set;
        logic [qcpc_pkg::EDGE_WIDTH-1:0]  edge_set;
        logic [qcpc_pkg::RATIO_WIDTH-1:0] edge_ratio_set;
        logic [qcpc_pkg::RATIO_WIDTH-1:0] diag_ratio_set;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Hand-made cells under the reset thresholds.
        foreach (cell_table[r])
        begin
            q.finite = cell_table[r].finite;
            for (k = 0; k < 4; k++)
            begin
                q.x[k] = CW'(cell_table[r].c[2 * k]);
                q.y[k] = CW'(cell_table[r].c[2 * k + 1]);
            end
            v.code      = cell_table[r].known ? cell_table[r].code : cell_verdict(q);
            v.plausible = (v.code == qcpc_pkg::FC_PASS);
            send_item(q, v);
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            // Thresholds change only with the pipe empty.
            while (awaited_verdicts.size() != 0) @(posedge clk);
            case (phase)
                0:
                begin
                    area_set       = qcpc_pkg::RESET_MIN_AREA;
                    edge_set       = qcpc_pkg::RESET_MIN_EDGE_LENGTH;
                    edge_ratio_set = qcpc_pkg::RESET_MAX_EDGE_RATIO;
                    diag_ratio_set = qcpc_pkg::RESET_MAX_DIAGONAL_RATIO;
                end
                1:
                begin
                    area_set       = '0;
                    edge_set       = '0;
                    edge_ratio_set = '1;
                    diag_ratio_set = '1;
                end
                2:
                begin
                    area_set       = '1;
                    edge_set       = '1;
                    edge_ratio_set = '1;
                    diag_ratio_set = '1;
                end
                3:
                begin
                    area_set       = '0;
                    edge_set       = '0;
                    edge_ratio_set = '0;
                    diag_ratio_set = 12'd255;
                end
                default:
                begin
                    area_set       = qcpc_pkg::AREA_WIDTH'($urandom_range(0, 40000));
                    edge_set       = qcpc_pkg::EDGE_WIDTH'($urandom_range(0, 200));
                    edge_ratio_set = qcpc_pkg::RATIO_WIDTH'($urandom_range(0, 1200));
                    diag_ratio_set = qcpc_pkg::RATIO_WIDTH'($urandom_range(0, 1200));
                end
            endcase
            write_threshold(qcpc_pkg::CFG_MIN_AREA,
                            qcpc_pkg::CFG_DATA_WIDTH'(area_set));
            write_threshold(qcpc_pkg::CFG_MIN_EDGE_LENGTH,
                            qcpc_pkg::CFG_DATA_WIDTH'(edge_set));
            write_threshold(qcpc_pkg::CFG_MAX_EDGE_RATIO,
                            qcpc_pkg::CFG_DATA_WIDTH'(edge_ratio_set));
            write_threshold(qcpc_pkg::CFG_MAX_DIAGONAL_RATIO,
                            qcpc_pkg::CFG_DATA_WIDTH'(diag_ratio_set));
            @(negedge clk);
            cfg_valid <= 1'b0;

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                q           = random_cell();
                v.code      = cell_verdict(q);
                v.plausible = (v.code == qcpc_pkg::FC_PASS);
                send_item(q, v);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (n_mismatch == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
